### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers shared by the accumulator machine
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define AM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/amach_pkg.sv
// ---------------------------------------------------------------------------
// amach_pkg
// types, constants and decode helpers for the accumulator machine
// ---------------------------------------------------------------------------
package amach_pkg;

    localparam int WORD_BITS = 32;
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_BITS = $clog2(MEM_DEPTH);
    localparam int PC_BITS   = 9;
    localparam int LEN_BITS  = 9;
    localparam int DIV_STEPS = WORD_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 2;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_EXEC  = 1'b1
    } cmd_t;

    typedef enum logic [3:0]
    {
        OP_NONE   = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MULT   = 4'd3,
        OP_DIV    = 4'd4,
        OP_JMP    = 4'd5,
        OP_JMPN   = 4'd6,
        OP_JMPP   = 4'd7,
        OP_JMPZ   = 4'd8,
        OP_COPY   = 4'd9,
        OP_LOAD   = 4'd10,
        OP_STORE  = 4'd11,
        OP_INPUT  = 4'd12,
        OP_OUTPUT = 4'd13,
        OP_STOP   = 4'd14
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_OPND,
        ST_VAL,
        ST_DST,
        ST_DIV,
        ST_RESP
    } state_t;

    typedef struct packed
    {
        cmd_t                  cmd;
        logic [ADDR_BITS-1:0]  address;
        logic [WORD_BITS-1:0]  data;
    } item_t;

    localparam logic [3:0] OP_TOP = 4'd15;

    function automatic op_t decode_op(input logic [WORD_BITS-1:0] w);
        op_t op;
        op = OP_NONE;
        if (w[WORD_BITS-1:4] == '0 && w[3:0] != OP_TOP)
        begin
            op = op_t'(w[3:0]);
        end
        return op;
    endfunction

    localparam int REG_PROGRAM_LENGTH = 0;

endpackage

### src/amach_if.sv
// ---------------------------------------------------------------------------
// amach_in_if / amach_out_if
// valid/ready channels for program and execute items and their results
// ---------------------------------------------------------------------------
interface amach_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [amach_pkg::ADDR_BITS-1:0]  address;
    logic [amach_pkg::WORD_BITS-1:0]  data;

    modport source (output valid, cmd, address, data, input ready);
    modport sink   (input valid, cmd, address, data, output ready);
endinterface

interface amach_out_if;
    logic                             valid;
    logic                             ready;
    logic                             out_valid;
    logic [amach_pkg::WORD_BITS-1:0]  out_value;
    logic                             input_taken;
    logic                             halted;
    logic                             fault;
    logic [amach_pkg::WORD_BITS-1:0]  acc_value;
    logic [amach_pkg::PC_BITS-1:0]    next_pc;

    modport source (output valid, out_valid, out_value, input_taken, halted, fault,
                    acc_value, next_pc, input ready);
    modport sink   (input valid, out_valid, out_value, input_taken, halted, fault,
                    acc_value, next_pc, output ready);
endinterface

### src/accumulator_machine_step.sv
// ---------------------------------------------------------------------------
// accumulator_machine_step
// accumulator machine with one word memory, one instruction per execute item
// ---------------------------------------------------------------------------
// in_ch carries items: cmd 0 stores data at address, cmd 1 runs the
// instruction at the program counter (data feeds INPUT). out_ch returns one
// result item per input item with the machine state after it.
// program_length is written over the APB port at byte address 0; write it
// only while no item is in flight.
// an input queue of two items sits ahead of the execution unit, so items are
// taken while a result waits on out_ch; a stalled out_ch holds the result and
// the queue fills, then in_ch.ready drops.
// an execute item reads the words it needs (opcode, operand, data word) one
// after another on the one memory port; DIV then runs the one-bit-per-cycle
// divider. with out_ch ready, items complete one after another, and the next
// item starts only once the result of the last has been taken.
// reset clears pc, accumulator, halt and fault flags and program_length;
// memory contents are undefined until written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module accumulator_machine_step
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    amach_in_if.sink                          in_ch,
    amach_out_if.source                       out_ch
);
    import amach_pkg::*;

    logic [LEN_BITS-1:0]  len_reg;
    logic                 q_valid;
    item_t                q_item;
    logic                 q_pop;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr == 3'(REG_PROGRAM_LENGTH * 4));
    assign prdata = (paddr == 3'(REG_PROGRAM_LENGTH * 4)) ? 32'(len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_wr)
        begin
            len_reg <= pwdata[LEN_BITS-1:0];
        end
    end

    amach_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    amach_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .program_length (len_reg),
        .out_ch         (out_ch)
    );

    // a fault always comes with a halt
    `AM_ASSERT_NOW(a_fault_halts, out_ch.valid && out_ch.fault, out_ch.halted)
    // one item never both reads data and reports a value
    `AM_ASSERT_NOW(a_one_effect, out_ch.valid && out_ch.out_valid, !out_ch.input_taken)
    // a machine that reports output had no fault before or during the item
    `AM_ASSERT_NOW(a_out_no_fault, out_ch.valid && out_ch.out_valid, !out_ch.fault)
    // once halted the machine stays halted
    `AM_ASSERT_NEXT(a_halt_sticky, out_ch.halted && !in_ch.valid && !q_valid, out_ch.halted)

endmodule

### src/amach_front.sv
// ---------------------------------------------------------------------------
// amach_front
// takes items off the input channel and queues them for the back
// ---------------------------------------------------------------------------
module amach_front
(
    input  logic              clk,
    input  logic              rst_n,
    amach_in_if.sink          in_ch,
    output logic              q_valid,
    output amach_pkg::item_t  q_item,
    input  logic              q_pop
);
    import amach_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);

    item_t                 fifo_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wptr_reg;
    logic [PTR_BITS-1:0]   rptr_reg;
    logic [PTR_BITS:0]     count_reg;
    logic [PTR_BITS:0]     count_next;
    logic                  push;
    logic                  pop;
    item_t                 in_item;

    assign in_ch.ready = (count_reg != (PTR_BITS+1)'(FIFO_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_pop && q_valid;
    assign q_valid     = (count_reg != '0);
    assign q_item      = fifo_reg[rptr_reg];

    always_comb
    begin
        in_item.cmd     = cmd_t'(in_ch.cmd);
        in_item.address = in_ch.address;
        in_item.data    = in_ch.data;
        count_next      = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/amach_div.sv
// ---------------------------------------------------------------------------
// amach_div
// signed divider, one quotient bit per cycle, truncating toward zero
// ---------------------------------------------------------------------------
module amach_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [amach_pkg::WORD_BITS-1:0]  dividend,
    input  logic [amach_pkg::WORD_BITS-1:0]  divisor,
    output logic                             done,
    output logic [amach_pkg::WORD_BITS-1:0]  quotient
);
    import amach_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [WORD_BITS-1:0]  rem_reg;
    logic [WORD_BITS-1:0]  quo_reg;
    logic [WORD_BITS-1:0]  dvs_reg;
    logic                  neg_reg;
    logic [WORD_BITS:0]    shifted;
    logic [WORD_BITS:0]    diff;
    logic                  fits;

    assign shifted  = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign fits     = !diff[WORD_BITS];
    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_BITS'(0) - quo_reg) : quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[WORD_BITS-1] ? (WORD_BITS'(0) - dividend) : dividend;
            dvs_reg <= divisor[WORD_BITS-1] ? (WORD_BITS'(0) - divisor) : divisor;
            neg_reg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            quo_reg <= {quo_reg[WORD_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/amach_back.sv
// ---------------------------------------------------------------------------
// amach_back
// carries out queued items against the single-port word memory
// ---------------------------------------------------------------------------
module amach_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  amach_pkg::item_t                  q_item,
    output logic                              q_pop,
    input  logic [amach_pkg::LEN_BITS-1:0]    program_length,
    amach_out_if.source                       out_ch
);
    import amach_pkg::*;

    logic [WORD_BITS-1:0]  mem [MEM_DEPTH];
    logic [WORD_BITS-1:0]  rdata_reg;
    logic [ADDR_BITS-1:0]  raddr;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  waddr;
    logic [WORD_BITS-1:0]  wdata;
    logic                  wr_en;

    state_t                state_reg;
    state_t                state_next;
    op_t                   op_reg;
    op_t                   op_next;
    op_t                   op_now;
    item_t                 item_reg;
    item_t                 item_next;
    logic [PC_BITS-1:0]    pc_reg;
    logic [PC_BITS-1:0]    pc_next;
    logic [WORD_BITS-1:0]  acc_reg;
    logic [WORD_BITS-1:0]  acc_next;
    logic                  halt_reg;
    logic                  halt_next;
    logic                  fault_reg;
    logic                  fault_next;
    logic                  ov_reg;
    logic                  ov_next;
    logic [WORD_BITS-1:0]  oval_reg;
    logic [WORD_BITS-1:0]  oval_next;
    logic                  itk_reg;
    logic                  itk_next;
    logic [WORD_BITS-1:0]  val_reg;
    logic [WORD_BITS-1:0]  val_next;

    logic                  finish;
    logic [PC_BITS-1:0]    fin_pc;
    logic                  div_start;
    logic                  div_done;
    logic [WORD_BITS-1:0]  div_q;
    logic [ADDR_BITS-1:0]  pc_lo;
    logic [PC_BITS-1:0]    pc_plus2;
    logic [PC_BITS-1:0]    jump_pc;
    logic                  acc_neg;
    logic                  acc_zero;

    amach_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (rdata_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign op_now   = decode_op(rdata_reg);
    assign pc_lo    = pc_reg[ADDR_BITS-1:0];
    assign pc_plus2 = pc_reg + PC_BITS'(2);
    assign jump_pc  = PC_BITS'(rdata_reg[ADDR_BITS-1:0]);
    assign acc_neg  = acc_reg[WORD_BITS-1];
    assign acc_zero = (acc_reg == '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.cmd == CMD_EXEC && !halt_reg && pc_reg < program_length)
                    begin
                        state_next = ST_DECODE;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_DECODE:
            begin
                if (op_now == OP_NONE || op_now == OP_STOP)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_OPND;
                end
            end
            ST_OPND:
            begin
                unique case (op_reg)
                    OP_JMP, OP_JMPN, OP_JMPP, OP_JMPZ, OP_STORE, OP_INPUT:
                        state_next = ST_RESP;
                    default:
                        state_next = ST_VAL;
                endcase
            end
            ST_VAL:
            begin
                if (op_reg == OP_COPY)
                begin
                    state_next = ST_DST;
                end
                else if (op_reg == OP_DIV && rdata_reg != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DST:
            begin
                state_next = ST_RESP;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        raddr      = pc_lo;
        wr_en      = 1'b0;
        waddr      = q_item.address;
        wdata      = q_item.data;
        div_start  = 1'b0;
        finish     = 1'b0;
        fin_pc     = pc_plus2;
        op_next    = op_reg;
        item_next  = item_reg;
        acc_next   = acc_reg;
        halt_next  = halt_reg;
        fault_next = fault_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        itk_next   = itk_reg;
        val_next   = val_reg;
        pc_next    = pc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    ov_next   = 1'b0;
                    oval_next = '0;
                    itk_next  = 1'b0;
                    if (q_item.cmd == CMD_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (!halt_reg)
                    begin
                        if (pc_reg >= program_length)
                        begin
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                end
            end
            ST_DECODE:
            begin
                op_next = op_now;
                if (op_now == OP_NONE)
                begin
                    finish = 1'b1;
                    fin_pc = pc_reg + PC_BITS'(1);
                end
                else if (op_now == OP_STOP)
                begin
                    halt_next = 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                    raddr = pc_lo + ADDR_BITS'(1);
                end
            end
            ST_OPND:
            begin
                waddr = rdata_reg[ADDR_BITS-1:0];
                raddr = rdata_reg[ADDR_BITS-1:0];
                unique case (op_reg)
                    OP_JMP:
                    begin
                        finish = 1'b1;
                        fin_pc = jump_pc;
                    end
                    OP_JMPN:
                    begin
                        finish = 1'b1;
                        fin_pc = acc_neg ? jump_pc : pc_plus2;
                    end
                    OP_JMPP:
                    begin
                        finish = 1'b1;
                        fin_pc = (!acc_neg && !acc_zero) ? jump_pc : pc_plus2;
                    end
                    OP_JMPZ:
                    begin
                        finish = 1'b1;
                        fin_pc = acc_zero ? jump_pc : pc_plus2;
                    end
                    OP_STORE:
                    begin
                        wr_en  = 1'b1;
                        wdata  = acc_reg;
                        finish = 1'b1;
                    end
                    OP_INPUT:
                    begin
                        wr_en    = 1'b1;
                        wdata    = item_reg.data;
                        itk_next = 1'b1;
                        finish   = 1'b1;
                    end
                    default:
                    begin
                        rd_en = 1'b1;
                    end
                endcase
            end
            ST_VAL:
            begin
                raddr = pc_lo + ADDR_BITS'(2);
                unique case (op_reg)
                    OP_ADD:
                    begin
                        acc_next = acc_reg + rdata_reg;
                        finish   = 1'b1;
                    end
                    OP_SUB:
                    begin
                        acc_next = acc_reg - rdata_reg;
                        finish   = 1'b1;
                    end
                    OP_MULT:
                    begin
                        acc_next = acc_reg * rdata_reg;
                        finish   = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        acc_next = rdata_reg;
                        finish   = 1'b1;
                    end
                    OP_OUTPUT:
                    begin
                        ov_next   = 1'b1;
                        oval_next = rdata_reg;
                        finish    = 1'b1;
                    end
                    OP_DIV:
                    begin
                        // zero divisor faults and leaves pc on the instruction
                        if (rdata_reg == '0)
                        begin
                            fault_next = 1'b1;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            div_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        val_next = rdata_reg;
                        rd_en    = 1'b1;
                    end
                endcase
            end
            ST_DST:
            begin
                wr_en  = 1'b1;
                waddr  = rdata_reg[ADDR_BITS-1:0];
                wdata  = val_reg;
                finish = 1'b1;
                fin_pc = pc_reg + PC_BITS'(3);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_next = div_q;
                    finish   = 1'b1;
                end
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            pc_next = fin_pc;
            if (fin_pc >= program_length)
            begin
                halt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        item_reg <= item_next;
        oval_reg <= oval_next;
        val_reg  <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            acc_reg   <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= 1'b0;
            ov_reg    <= 1'b0;
            itk_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_next;
            halt_reg  <= halt_next;
            fault_reg <= fault_next;
            ov_reg    <= ov_next;
            itk_reg   <= itk_next;
        end
    end

    assign out_ch.valid       = (state_reg == ST_RESP);
    assign out_ch.out_valid   = ov_reg;
    assign out_ch.out_value   = oval_reg;
    assign out_ch.input_taken = itk_reg;
    assign out_ch.halted      = halt_reg;
    assign out_ch.fault       = fault_reg;
    assign out_ch.acc_value   = acc_reg;
    assign out_ch.next_pc     = pc_reg;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// accumulator machine step testbench
// ----------------------------------------------------------------------------
// Runs one long program on accumulator_machine_step. Instructions are planted
// at the program counter and executed one item at a time. A behavioral copy
// of the machine predicts every result, and results are compared field by
// field. The program_length register is changed between phases. The run ends
// with the machine halted by STOP, divide by zero or end of program.
// ----------------------------------------------------------------------------
module testbench;
    import amach_pkg::*;

    typedef struct packed
    {
        logic        out_valid;
        logic [31:0] out_value;
        logic        input_taken;
        logic        halted;
        logic        fault;
        logic [31:0] acc_value;
        logic [8:0]  next_pc;
    } result_t;

    // directed program row: instruction, operands, input data, typed check
    typedef enum int { CHK_NONE, CHK_ACC, CHK_PC, CHK_OUT } chk_t;
    typedef struct
    {
        logic [31:0] opw;
        logic [31:0] op1;
        logic [31:0] op2;
        logic [31:0] din;
        chk_t        chk;
        logic [31:0] val;
    } row_t;

    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_NEG1 = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    amach_in_if  in_bus ();
    amach_out_if out_bus ();

    accumulator_machine_step u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    // machine copy used for prediction
    logic [31:0] mach_mem [256];
    logic [8:0]  mach_pc;
    logic [31:0] mach_acc;
    logic        mach_halt;
    logic        mach_fault;
    logic [8:0]  mach_len;

    result_t pending_results[$];
    int mismatches;
    int n_exec;
    int n_write;
    int n_output;
    int n_input;
    int n_checked;
    int rx_stall;
    int hold_request;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'd0;
            1: w = 32'd1;
            2: w = W_NEG1;
            3: w = W_MIN;
            4: w = W_MAX;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // one item through the machine copy
    function automatic result_t run_item(input logic c, input logic [7:0] a,
                                         input logic [31:0] d);
        result_t r;
        logic [31:0] w;
        logic [31:0] opnd;
        logic [31:0] val;
        logic [9:0] nxt;
        op_t op;
        r = '0;
        if (c == CMD_WRITE)
        begin
            mach_mem[a] = d;
        end
        else if (!mach_halt)
        begin
            if (mach_pc >= mach_len)
            begin
                mach_halt = 1'b1;
            end
            else
            begin
                w = mach_mem[mach_pc[7:0]];
                opnd = mach_mem[8'(mach_pc + 9'd1)];
                val = mach_mem[opnd[7:0]];
                nxt = 10'(mach_pc) + 10'd2;
                op = (w > 32'd14) ? OP_NONE : op_t'(w[3:0]);
                case (op)
                    OP_ADD: mach_acc = mach_acc + val;
                    OP_SUB: mach_acc = mach_acc - val;
                    OP_MULT: mach_acc = mach_acc * val;
                    OP_DIV:
                    begin
                        if (val == 32'd0)
                        begin
                            mach_fault = 1'b1;
                            mach_halt = 1'b1;
                            nxt = 10'(mach_pc);
                        end
                        else if (!(mach_acc == W_MIN && val == W_NEG1))
                        begin
                            mach_acc = $signed(mach_acc) / $signed(val);
                        end
                    end
                    OP_JMP: nxt = 10'(opnd[7:0]);
                    OP_JMPN: if (mach_acc[31]) nxt = 10'(opnd[7:0]);
                    OP_JMPP: if (!mach_acc[31] && mach_acc != 0) nxt = 10'(opnd[7:0]);
                    OP_JMPZ: if (mach_acc == 0) nxt = 10'(opnd[7:0]);
                    OP_COPY:
                    begin
                        mach_mem[mach_mem[8'(mach_pc + 9'd2)][7:0]] = val;
                        nxt = 10'(mach_pc) + 10'd3;
                    end
                    OP_LOAD: mach_acc = val;
                    OP_STORE: mach_mem[opnd[7:0]] = mach_acc;
                    OP_INPUT:
                    begin
                        mach_mem[opnd[7:0]] = d;
                        r.input_taken = 1'b1;
                    end
                    OP_OUTPUT:
                    begin
                        r.out_value = val;
                        r.out_valid = 1'b1;
                    end
                    OP_STOP:
                    begin
                        mach_halt = 1'b1;
                        nxt = 10'(mach_pc);
                    end
                    default: nxt = 10'(mach_pc) + 10'd1;
                endcase
                mach_pc = (nxt > 10'd511) ? 9'd511 : nxt[8:0];
                if (mach_pc >= mach_len)
                begin
                    mach_halt = 1'b1;
                end
            end
        end
        r.halted = mach_halt;
        r.fault = mach_fault;
        r.acc_value = mach_acc;
        r.next_pc = mach_pc;
        return r;
    endfunction

    // would this instruction, planted at pc, stop the machine
    function automatic bit stops_machine(input logic [31:0] opw, input logic [31:0] o1,
                                         input logic [31:0] o2, input logic [31:0] d);
        logic [31:0] keep_mem [256];
        logic [8:0] keep_pc;
        logic [31:0] keep_acc;
        logic keep_halt;
        logic keep_fault;
        result_t r;
        keep_mem = mach_mem;
        keep_pc = mach_pc;
        keep_acc = mach_acc;
        keep_halt = mach_halt;
        keep_fault = mach_fault;
        mach_mem[mach_pc[7:0]] = opw;
        mach_mem[8'(mach_pc + 9'd1)] = o1;
        if (opw == 32'(OP_COPY))
        begin
            mach_mem[8'(mach_pc + 9'd2)] = o2;
        end
        r = run_item(CMD_EXEC, 8'd0, d);
        mach_mem = keep_mem;
        mach_pc = keep_pc;
        mach_acc = keep_acc;
        mach_halt = keep_halt;
        mach_fault = keep_fault;
        return r.halted;
    endfunction

    // drive one item, predict on accept; typed fields override the prediction
    task automatic send_item(input logic c, input logic [7:0] a, input logic [31:0] d,
                             input chk_t chk, input logic [31:0] tval);
        int gap;
        result_t r;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.cmd = c;
        in_bus.address = a;
        in_bus.data = d;
        in_bus.valid = 1'b1;
        do @(posedge clk); while (!in_bus.ready);
        r = run_item(c, a, d);
        case (chk)
            CHK_ACC: r.acc_value = tval;
            CHK_PC: r.next_pc = tval[8:0];
            CHK_OUT: r.out_value = tval;
            default: ;
        endcase
        pending_results = {pending_results, r};
        if (c == CMD_WRITE) n_write++; else n_exec++;
    endtask

    task automatic plant_and_run(input logic [31:0] opw, input logic [31:0] o1,
                                 input logic [31:0] o2, input logic [31:0] d,
                                 input chk_t chk, input logic [31:0] tval);
        send_item(CMD_WRITE, mach_pc[7:0], opw, CHK_NONE, 0);
        send_item(CMD_WRITE, 8'(mach_pc + 9'd1), o1, CHK_NONE, 0);
        if (opw == 32'(OP_COPY))
        begin
            send_item(CMD_WRITE, 8'(mach_pc + 9'd2), o2, CHK_NONE, 0);
        end
        send_item(CMD_EXEC, 8'($urandom), d, chk, tval);
    endtask

    // register write and read-back, only with nothing in flight
    task automatic write_length(input logic [8:0] len);
        @(negedge clk);
        in_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 3'(REG_PROGRAM_LENGTH * 4);
        pwdata = 32'(len);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        mach_len = len;
        psel = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[8:0] != len)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("program_length read back %0d, wrote %0d", prdata[8:0], len);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic random_step();
        logic [31:0] opw;
        logic [31:0] o1;
        logic [31:0] o2;
        logic [31:0] d;
        int pick;
        pick = $urandom_range(0, 99);
        d = rand_word();
        if (pick < 10)
        begin
            send_item(CMD_WRITE, 8'($urandom), rand_word(), CHK_NONE, 0);
            return;
        end
        if (pick < 30 && !stops_machine(mach_mem[mach_pc[7:0]],
                                        mach_mem[8'(mach_pc + 9'd1)],
                                        mach_mem[8'(mach_pc + 9'd2)], d))
        begin
            send_item(CMD_EXEC, 8'($urandom), d, CHK_NONE, 0);
            return;
        end
        if ($urandom_range(0, 9) < 8)
            opw = 32'($urandom_range(1, 13));
        else
            opw = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
        o1 = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 255));
        o2 = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 255));
        if (opw == 32'(OP_STOP) || stops_machine(opw, o1, o2, d))
        begin
            opw = 32'(OP_JMP);
            o1 = 32'($urandom_range(0, mach_len - 12));
        end
        plant_and_run(opw, o1, o2, d, CHK_NONE, 0);
    endtask

    // receiver ready, with per-item stalls and one long hold-off
    initial
    begin
        int long_hold;
        long_hold = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                long_hold = 150;
                hold_request = 0;
            end
            if (long_hold > 0)
            begin
                out_bus.ready = 1'b0;
                long_hold--;
            end
            else if (rx_stall > 0)
            begin
                out_bus.ready = 1'b0;
                rx_stall--;
            end
            else
            begin
                out_bus.ready = 1'b1;
            end
        end
    end

    // result checker
    initial
    begin
        result_t want;
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_bus.valid && out_bus.ready)
            begin
                got.out_valid = out_bus.out_valid;
                got.out_value = out_bus.out_value;
                got.input_taken = out_bus.input_taken;
                got.halted = out_bus.halted;
                got.fault = out_bus.fault;
                got.acc_value = out_bus.acc_value;
                got.next_pc = out_bus.next_pc;
                rx_stall = draw_gap();
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (got.out_valid) n_output++;
                    if (got.input_taken) n_input++;
                    if (got.out_valid !== want.out_valid || got.out_value !== want.out_value
                        || got.input_taken !== want.input_taken
                        || got.halted !== want.halted || got.fault !== want.fault
                        || got.acc_value !== want.acc_value || got.next_pc !== want.next_pc)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: expected %p got %p",
                                     n_checked, want, got);
                    end
                end
            end
        end
    end

    initial
    begin
        row_t prog [23];
        logic [8:0] len;
        int kind;
        prog = '{
            '{32'(OP_LOAD),   32'd200, 0, 0, CHK_ACC, W_MAX},
            '{32'(OP_ADD),    32'd204, 0, 0, CHK_ACC, W_MIN},
            '{32'(OP_SUB),    32'd204, 0, 0, CHK_ACC, W_MAX},
            '{32'(OP_LOAD),   32'd201, 0, 0, CHK_ACC, W_MIN},
            '{32'(OP_DIV),    32'd202, 0, 0, CHK_ACC, W_MIN},
            '{32'(OP_MULT),   32'd202, 0, 0, CHK_ACC, W_MIN},
            '{32'(OP_JMPN),   32'd40,  0, 0, CHK_PC, 32'd40},
            '{32'(OP_LOAD),   32'd203, 0, 0, CHK_ACC, 32'd0},
            '{32'(OP_JMPZ),   32'hFFFF_FF32, 0, 0, CHK_PC, 32'h32},
            '{32'(OP_JMPP),   32'd60,  0, 0, CHK_PC, 32'h34},
            '{32'(OP_JMPN),   32'd60,  0, 0, CHK_PC, 32'h36},
            '{32'(OP_ADD),    32'd204, 0, 0, CHK_ACC, 32'd1},
            '{32'(OP_JMPP),   32'd70,  0, 0, CHK_PC, 32'd70},
            '{32'(OP_OUTPUT), 32'd200, 0, 0, CHK_OUT, W_MAX},
            '{32'(OP_INPUT),  32'd205, 0, W_MIN, CHK_NONE, 0},
            '{32'(OP_OUTPUT), 32'd205, 0, 0, CHK_OUT, W_MIN},
            '{32'(OP_STORE),  32'd206, 0, 0, CHK_NONE, 0},
            '{32'(OP_COPY),   32'd201, 32'd207, 0, CHK_NONE, 0},
            '{32'(OP_OUTPUT), 32'd207, 0, 0, CHK_OUT, W_MIN},
            '{32'(OP_NONE),   32'd0,   0, 0, CHK_NONE, 0},
            '{32'(OP_TOP),    32'd0,   0, 0, CHK_NONE, 0},
            '{32'hFFFF_FFFE,  32'd0,   0, 0, CHK_NONE, 0},
            '{32'h0000_0011,  32'd0,   0, 0, CHK_NONE, 0}
        };
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.cmd = CMD_WRITE;
        in_bus.address = '0;
        in_bus.data = '0;
        mach_pc = '0;
        mach_acc = '0;
        mach_halt = 1'b0;
        mach_fault = 1'b0;
        mach_len = '0;
        mismatches = 0;
        n_exec = 0;
        n_write = 0;
        n_output = 0;
        n_input = 0;
        n_checked = 0;
        rx_stall = 0;
        hold_request = 0;
        calm = 1'b0;
        foreach (mach_mem[i]) mach_mem[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every cell written once, so nothing unwritten is ever read
        write_length(9'd0);
        for (int i = 0; i < 256; i++)
        begin
            case (i)
                200: send_item(CMD_WRITE, 8'(i), W_MAX, CHK_NONE, 0);
                201: send_item(CMD_WRITE, 8'(i), W_MIN, CHK_NONE, 0);
                202: send_item(CMD_WRITE, 8'(i), W_NEG1, CHK_NONE, 0);
                203: send_item(CMD_WRITE, 8'(i), 32'd0, CHK_NONE, 0);
                204: send_item(CMD_WRITE, 8'(i), 32'd1, CHK_NONE, 0);
                default: send_item(CMD_WRITE, 8'(i), rand_word(), CHK_NONE, 0);
            endcase
        end

        write_length(9'd256);
        foreach (prog[i])
            plant_and_run(prog[i].opw, prog[i].op1, prog[i].op2, prog[i].din,
                          prog[i].chk, prog[i].val);

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
            begin
                len = (ph == 3) ? 9'd256 : 9'($urandom_range(64, 255));
                if (len < mach_pc + 9'd16) len = 9'd256;
                write_length(len);
            end
            for (int k = 0; k < 150; k++)
            begin
                if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
                if (ph == 1 && k == 50) hold_request = 1;
                random_step();
            end
        end
        calm = 1'b0;

        // bring the machine to a stop, one way per run
        plant_and_run(32'(OP_JMP), 32'd10, 0, 0, CHK_PC, 32'd10);
        kind = $urandom_range(0, 2);
        if (kind == 0)
        begin
            plant_and_run(32'(OP_STOP), 32'd0, 0, 0, CHK_PC, 32'd10);
        end
        else if (kind == 1)
        begin
            send_item(CMD_WRITE, 8'd203, 32'd0, CHK_NONE, 0);
            plant_and_run(32'(OP_DIV), 32'd203, 0, 0, CHK_PC, 32'd10);
        end
        else
        begin
            write_length(9'd12);
            plant_and_run(32'(OP_ADD), 32'd204, 0, 0, CHK_PC, 32'd12);
        end
        send_item(CMD_EXEC, 8'd0, $urandom, CHK_NONE, 0);
        send_item(CMD_WRITE, 8'd250, $urandom, CHK_NONE, 0);
        write_length(9'd0);
        send_item(CMD_EXEC, 8'd255, $urandom, CHK_NONE, 0);
        send_item(CMD_EXEC, 8'd1, $urandom, CHK_NONE, 0);

        @(negedge clk);
        in_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("ran %0d execute and %0d write items, %0d results checked",
                 n_exec, n_write, n_checked);
        $display("%0d outputs, %0d inputs taken, final stop kind %0d",
                 n_output, n_input, kind);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
